@@ rtl/timer_deadline_min_heap_core_macros.svh @@
// assertion helpers
`ifndef TIMER_DEADLINE_MIN_HEAP_CORE_MACROS_SVH
`define TIMER_DEADLINE_MIN_HEAP_CORE_MACROS_SVH
`define TDMH_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define TDMH_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`endif

@@ rtl/tdmh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tdmh_pkg;
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PEEK   = 2'd2,
      OP_EXPIRE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_NOID  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND,
      S_DROP,
      S_CHKFULL,
      S_PLACE,
      S_SHIFTUP,
      S_WRNEW,
      S_PEEK,
      S_EXPSCAN,
      S_EXPEMIT,
      S_COMPACT,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

@@ rtl/tdmh_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tdmh_store
   import tdmh_pkg::*;
#(
   parameter int DEPTH      = 32,
   parameter int ID_WIDTH   = 8,
   parameter int TIME_WIDTH = 32,
   localparam int AW        = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [ID_WIDTH-1:0]   wr_id,
   input  wire logic [TIME_WIDTH-1:0] wr_dl,
   input  wire logic [AW-1:0]         rd_addr,
   output logic      [ID_WIDTH-1:0]   rd_id,
   output logic      [TIME_WIDTH-1:0] rd_dl
);
   logic [ID_WIDTH+TIME_WIDTH-1:0] mem [DEPTH];
   logic [ID_WIDTH+TIME_WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_id, wr_dl};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_id = rd_ff[ID_WIDTH+TIME_WIDTH-1:TIME_WIDTH];
   assign rd_dl = rd_ff[TIME_WIDTH-1:0];
endmodule
`default_nettype wire

@@ rtl/timer_deadline_min_heap_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  fields (lsb first)
// req_     in   tdata: operation, event_id, deadline, now_time
// rsp_     out  tdata: entry_valid, entry_id, entry_deadline, status, occupancy; tlast: last
// One sorted store in a RAM with one registered read port, earliest at slot 0.
// Insert/remove: linear scan for the id, then shifts; insert then scans for its place,
// shifts the tail up and writes the new entry. Peek: reads slot 0. Expire: scan, then one word
// per due entry (each waits until the previous word is taken on rsp_), then compaction.
// Reset clears the state, count and pending flags; the RAM needs no clearing. A stall on rsp_ holds the word.
module timer_deadline_min_heap_core
   import tdmh_pkg::*;
#(
   parameter int DEPTH      = 32,
   parameter int ID_WIDTH   = 8,
   parameter int TIME_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // operation, event_id, deadline, now_time
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,  // entry_valid, entry_id, entry_deadline, status,
                                        // occupancy
   output logic             rsp_tlast
);
`include "timer_deadline_min_heap_core_macros.svh"
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] due_ff, due_in;
   op_type op_ff, op_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [TIME_WIDTH-1:0] dl_ff, dl_in, now_ff, now_in;
   logic rv_ff, rv_in, rlast_ff, rlast_in, rent_ff, rent_in;
   logic [7:0] rid_ff, rid_in;
   logic [31:0] rdl_ff, rdl_in;
   status_type rst_ff, rst_in;
   logic [5:0] rocc_ff, rocc_in;
   logic pend_ff, pend_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [ID_WIDTH-1:0] wr_id, rd_id;
   logic [TIME_WIDTH-1:0] wr_dl, rd_dl;

   tdmh_store #(.DEPTH(DEPTH), .ID_WIDTH(ID_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_id(wr_id), .wr_dl(wr_dl),
      .rd_addr(rd_addr), .rd_id(rd_id), .rd_dl(rd_dl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
      end
      idx_ff <= idx_in; due_ff <= due_in; op_ff <= op_in; id_ff <= id_in;
      dl_ff <= dl_in; now_ff <= now_in; rlast_ff <= rlast_in; rent_ff <= rent_in;
      rid_ff <= rid_in; rdl_ff <= rdl_in; rst_ff <= rst_in; rocc_ff <= rocc_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {7'd0, rocc_ff, rst_ff, rdl_ff, rid_ff, rent_ff};

   // pend_ff: the read issued last cycle is now valid on rd_*
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; idx_in = idx_ff; due_in = due_ff;
      op_in = op_ff; id_in = id_ff; dl_in = dl_ff; now_in = now_ff;
      rv_in = rv_ff; rlast_in = rlast_ff; rent_in = rent_ff; rid_in = rid_ff;
      rdl_in = rdl_ff; rst_in = rst_ff; rocc_in = rocc_ff; pend_in = 1'b0;
      wr_en = 1'b0; wr_addr = '0; wr_id = '0; wr_dl = '0; rd_addr = idx_ff[AW-1:0];
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in  = op_type'(req_tdata[1:0]);
               id_in  = req_tdata[2 +: ID_WIDTH];
               dl_in  = TIME_WIDTH'(req_tdata[10 +: 32]);
               now_in = TIME_WIDTH'(req_tdata[42 +: 32]);
               idx_in = '0;
               unique case (op_type'(req_tdata[1:0]))
                  OP_INSERT, OP_REMOVE: state_in = S_FIND;
                  OP_PEEK:              state_in = S_PEEK;
                  default:              state_in = S_EXPSCAN;
               endcase
            end
         end
         S_FIND: begin
            if (!pend_ff) begin
               if (idx_ff >= cnt_ff) begin
                  if (op_ff == OP_REMOVE) begin
                     rst_in = ST_NOID; state_in = S_RESP;
                  end else begin
                     state_in = S_CHKFULL;
                  end
               end else begin
                  pend_in = 1'b1;
               end
            end else if (rd_id == id_ff) begin
               state_in = S_DROP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DROP: begin
            // move idx+1 down to idx
            if (!pend_ff) begin
               if (CW'(idx_ff + 1'b1) >= cnt_ff) begin
                  cnt_in = cnt_ff - 1'b1;
                  if (op_ff == OP_REMOVE) begin
                     rst_in = ST_OK; state_in = S_RESP;
                  end else begin
                     state_in = S_CHKFULL;
                  end
               end else begin
                  rd_addr = AW'(idx_ff + 1'b1);
                  pend_in = 1'b1;
               end
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_id = rd_id; wr_dl = rd_dl;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CHKFULL: begin
            if (cnt_ff == CW'(DEPTH)) begin
               rst_in = ST_FULL; state_in = S_RESP;
            end else begin
               idx_in = '0; state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (!pend_ff) begin
               if (idx_ff >= cnt_ff) begin
                  due_in = idx_ff; idx_in = cnt_ff; state_in = S_SHIFTUP;
               end else begin
                  pend_in = 1'b1;
               end
            end else if (rd_dl <= dl_ff) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               due_in = idx_ff; idx_in = cnt_ff; state_in = S_SHIFTUP;
            end
         end
         S_SHIFTUP: begin
            // idx_ff = destination, move idx-1 up, down to insert point due_ff
            if (!pend_ff) begin
               if (idx_ff <= due_ff) begin
                  state_in = S_WRNEW;
               end else begin
                  rd_addr = AW'(idx_ff - 1'b1);
                  pend_in = 1'b1;
               end
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_id = rd_id; wr_dl = rd_dl;
               idx_in = idx_ff - 1'b1;
            end
         end
         S_WRNEW: begin
            wr_en = 1'b1; wr_addr = due_ff[AW-1:0]; wr_id = id_ff; wr_dl = dl_ff;
            cnt_in = cnt_ff + 1'b1; rst_in = ST_OK; state_in = S_RESP;
         end
         S_PEEK: begin
            if (cnt_ff == '0) begin
               rst_in = ST_EMPTY; state_in = S_RESP;
            end else if (!pend_ff) begin
               rd_addr = '0; pend_in = 1'b1;
            end else begin
               rst_in = ST_OK; rent_in = 1'b1; state_in = S_RESP;
               rid_in = 8'(rd_id); rdl_in = 32'(rd_dl);
            end
         end
         S_EXPSCAN: begin
            if (!pend_ff) begin
               if (idx_ff >= cnt_ff) begin
                  due_in = idx_ff; idx_in = '0;
                  state_in = (idx_ff == '0) ? S_RESP : S_EXPEMIT;
                  rst_in = ST_EMPTY;
               end else begin
                  pend_in = 1'b1;
               end
            end else if (rd_dl <= now_ff) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               due_in = idx_ff; idx_in = '0;
               state_in = (idx_ff == '0) ? S_RESP : S_EXPEMIT;
               rst_in = ST_EMPTY;
            end
         end
         S_EXPEMIT: begin
            if (!pend_ff) begin
               if (!rv_ff) pend_in = 1'b1;
               else pend_in = 1'b0;
            end else begin
               rv_in = 1'b1; rent_in = 1'b1; rst_in = ST_OK;
               rid_in = 8'(rd_id); rdl_in = 32'(rd_dl);
               rocc_in = 6'(cnt_ff - due_ff);
               rlast_in = (CW'(idx_ff + 1'b1) == due_ff);
               idx_in = idx_ff + 1'b1;
               if (CW'(idx_ff + 1'b1) == due_ff) begin
                  idx_in = '0; state_in = S_COMPACT;
               end
            end
         end
         S_COMPACT: begin
            // move idx+due down to idx
            if (!pend_ff) begin
               if (CW'(idx_ff + due_ff) >= cnt_ff) begin
                  cnt_in = cnt_ff - due_ff; state_in = S_IDLE;
               end else begin
                  rd_addr = AW'(idx_ff + due_ff);
                  pend_in = 1'b1;
               end
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_id = rd_id; wr_dl = rd_dl;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rv_ff) begin
               rv_in = 1'b1; rlast_in = 1'b1;
               rocc_in = 6'(cnt_ff);
               if (!(state_ff == S_RESP && rent_ff && rst_ff == ST_OK)) begin
                  rent_in = 1'b0; rid_in = '0; rdl_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // entry fields only survive into S_RESP from peek
      if (state_ff != S_PEEK && state_ff != S_EXPEMIT && state_in == S_RESP) begin
         rent_in = 1'b0;
      end
   end

   `TDMH_ASSERT(a_cnt_range, cnt_ff <= CW'(DEPTH), "entry count above depth")
   `TDMH_ASSERT(a_busy_ready, !(req_tready && state_ff != S_IDLE), "ready while busy")
   `TDMH_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata),
      "result changed under stall")
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import tdmh_pkg::*;

   localparam int SLOTS = 32;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic        valid;
      logic [7:0]  id;
      logic [31:0] deadline;
      status_type  status;
      logic        last;
      logic [5:0]  occupancy;
   } timer_word;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic rsp_tlast;

   timer_deadline_min_heap_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // timer store as the block should hold it
   logic [7:0]  held_ids[$];
   logic [31:0] held_deadlines[$];
   timer_word   due_words[$];
   logic [79:0] pending_words[$];
   int errors = 0;
   int idle_cycles = 0;
   bit stimulus_done = 0;
   int hold_off = 0;

   function automatic timer_word make_word(logic v, logic [7:0] id, logic [31:0] dl,
                                           status_type st, logic l, int occ);
      timer_word w;
      w.valid = v; w.id = id; w.deadline = dl; w.status = st; w.last = l;
      w.occupancy = occ[5:0];
      return w;
   endfunction

   function automatic void queue_result(timer_word w);
      due_words.insert(due_words.size(), w);
   endfunction

   function automatic void queue_request(logic [79:0] w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic int find_timer(logic [7:0] id);
      for (int i = 0; i < held_ids.size(); i++) if (held_ids[i] == id) return i;
      return -1;
   endfunction

   task automatic predict_timer(logic [79:0] w);
      op_type op;
      logic [7:0] id;
      logic [31:0] dl, now;
      int at, due;
      op = op_type'(w[1:0]);
      id = w[9:2];
      dl = w[41:10];
      now = w[73:42];
      case (op)
         OP_INSERT: begin
            at = find_timer(id);
            if (at >= 0) begin
               held_ids.delete(at);
               held_deadlines.delete(at);
            end
            if (held_ids.size() >= SLOTS) begin
               queue_result(make_word(0, 0, 0, ST_FULL, 1, held_ids.size()));
            end else begin
               at = 0;
               while (at < held_ids.size() && held_deadlines[at] <= dl) at++;
               held_ids.insert(at, id);
               held_deadlines.insert(at, dl);
               queue_result(make_word(0, 0, 0, ST_OK, 1, held_ids.size()));
            end
         end
         OP_REMOVE: begin
            at = find_timer(id);
            if (at < 0) begin
               queue_result(make_word(0, 0, 0, ST_NOID, 1, held_ids.size()));
            end else begin
               held_ids.delete(at);
               held_deadlines.delete(at);
               queue_result(make_word(0, 0, 0, ST_OK, 1, held_ids.size()));
            end
         end
         OP_PEEK: begin
            if (held_ids.size() == 0)
               queue_result(make_word(0, 0, 0, ST_EMPTY, 1, 0));
            else
               queue_result(make_word(1, held_ids[0], held_deadlines[0], ST_OK, 1,
                                      held_ids.size()));
         end
         default: begin
            due = 0;
            while (due < held_ids.size() && held_deadlines[due] <= now) due++;
            if (due == 0)
               queue_result(make_word(0, 0, 0, ST_EMPTY, 1, held_ids.size()));
            for (int k = 0; k < due; k++)
               queue_result(make_word(1, held_ids[k], held_deadlines[k], ST_OK,
                                      k + 1 == due, held_ids.size() - due));
            for (int k = 0; k < due; k++) begin
               held_ids.pop_front();
               held_deadlines.pop_front();
            end
         end
      endcase
   endtask

   function automatic logic [79:0] pack_req(op_type op, logic [7:0] id, logic [31:0] dl,
                                            logic [31:0] now);
      return {6'd0, now, dl, id, op};
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_timer(req_tdata);
            send_gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap == 0 && pending_words.size() > 0) begin
               req_tdata <= pending_words.pop_front();
               req_tvalid <= 1;
            end else begin
               if (send_gap > 0) send_gap--;
               req_tvalid <= 0;
            end
         end
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      timer_word got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[40:9], status_type'(rsp_tdata[42:41]),
                   rsp_tlast, rsp_tdata[48:43]};
            if (due_words.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word %h", got);
            end else begin
               want = due_words.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
               end
            end
            recv_gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) recv_gap = 0;
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   initial begin
      logic [7:0] id;
      logic [31:0] base;
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed
      queue_request(pack_req(OP_PEEK, 0, 0, 0));
      queue_request(pack_req(OP_EXPIRE, 0, 0, 32'hffffffff));
      queue_request(pack_req(OP_REMOVE, 8'hff, 0, 0));
      queue_request(pack_req(OP_INSERT, 8'h00, 32'hffffffff, 32'hffffffff));
      queue_request(pack_req(OP_INSERT, 8'hff, 32'h0, 0));
      queue_request(pack_req(OP_INSERT, 8'h55, 32'h100, 0));
      queue_request(pack_req(OP_INSERT, 8'haa, 32'h100, 0));
      queue_request(pack_req(OP_PEEK, 0, 0, 0));
      queue_request(pack_req(OP_INSERT, 8'hff, 32'h200, 0));
      queue_request(pack_req(OP_EXPIRE, 0, 0, 32'h0ff));
      queue_request(pack_req(OP_REMOVE, 8'h55, 0, 0));
      queue_request(pack_req(OP_EXPIRE, 0, 0, 32'hfffffffe));
      queue_request(pack_req(OP_EXPIRE, 0, 0, 32'hffffffff));
      // fill the store, refuse one, replace while full, drain all
      for (int i = 0; i < SLOTS; i++)
         queue_request(pack_req(OP_INSERT, i[7:0], $urandom_range(0, 1000), 0));
      queue_request(pack_req(OP_INSERT, 8'h80, 5, 0));
      queue_request(pack_req(OP_INSERT, 8'h03, 7, 0));
      queue_request(pack_req(OP_EXPIRE, 0, 0, 32'hffffffff));
      // receiver holds off while the sender keeps offering
      hold_off = 400;
      // random: timelines with rising now
      base = 0;
      for (int n = 0; n < 332; n++) begin
         id = (n % 5 == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: queue_request(pack_req(OP_INSERT, id,
               ($urandom_range(0, 7) == 0) ? $urandom : base + $urandom_range(0, 3000),
               $urandom));
            4, 5: queue_request(pack_req(OP_REMOVE, id, $urandom, $urandom));
            6: queue_request(pack_req(OP_PEEK, id, $urandom, $urandom));
            default: begin
               base = base + $urandom_range(0, 800);
               queue_request(pack_req(OP_EXPIRE, id, $urandom,
                  ($urandom_range(0, 9) == 0) ? $urandom : base));
            end
         endcase
      end
      stimulus_done = 1;
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
         if (stimulus_done && pending_words.size() == 0 && !req_tvalid
             && due_words.size() == 0) begin
            repeat (300) @(posedge clock);
            if (errors == 0 && due_words.size() == 0) begin
               $display("simulation ok");
            end else begin
               $display("simulation failed");
            end
            $finish;
         end
      end
   end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tdmh_pkg.sv
rtl/tdmh_store.sv
rtl/timer_deadline_min_heap_core.sv
bench/testbench.sv
